>>> hdl/vitk7_pkg.sv
`timescale 1ns / 1ps

package vitk7_pkg;

    localparam int SOFT_W    = 4;
    localparam int BYTE_W    = 8;
    localparam int METRIC_W  = 25;
    localparam int SURV_W    = 64;
    localparam int NSTATE_W  = 6;
    localparam int HALF_W    = 5;
    localparam int PAIR_W    = 7;
    localparam int BM_W      = 5;
    localparam int RAM_DEPTH = 128;

    localparam logic [METRIC_W-1:0] INIT_METRIC = METRIC_W'(16843009);
    localparam logic [BM_W-1:0]     BM_MAX      = 5'd30;
    localparam logic [SOFT_W-1:0]   DIST_ZERO   = 4'h7;
    localparam logic [SOFT_W-1:0]   DIST_ONE    = 4'h8;
    localparam logic [PAIR_W-1:0]   FIRST_EMIT  = 7'd63;

    // branch output class of each butterfly, indexed by its lower predecessor
    localparam logic [1:0] BM_GROUP [32] = '{
        2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd3,
        2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd3,
        2'd0, 2'd2, 2'd3, 2'd1, 2'd3, 2'd1, 2'd0, 2'd2,
        2'd0, 2'd2, 2'd3, 2'd1, 2'd3, 2'd1, 2'd0, 2'd2
    };

    typedef struct packed {
        logic [METRIC_W-1:0] metric;
        logic [SURV_W-1:0]   surv;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACS,
        S_EMIT
    } t_state;

endpackage

>>> hdl/vitk7_in_if.sv
`timescale 1ns / 1ps

interface vitk7_in_if import vitk7_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SOFT_W-1:0] soft_first;
    logic [SOFT_W-1:0] soft_second;

    modport source (output valid, output soft_first, output soft_second, input ready);
    modport sink   (input valid, input soft_first, input soft_second, output ready);
endinterface

>>> hdl/vitk7_out_if.sv
`timescale 1ns / 1ps

interface vitk7_out_if import vitk7_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              page_last;

    modport source (output valid, output out_byte, output page_last, input ready);
    modport sink   (input valid, input out_byte, input page_last, output ready);
endinterface

>>> hdl/vitk7_ram.sv
`timescale 1ns / 1ps

module vitk7_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/viterbi_k7_soft_decoder_unit.sv
`timescale 1ns / 1ps

// K=7 rate-1/2 soft-decision viterbi decoder. One input beat carries a pair of 4-bit soft
// symbols; the 64 path metrics and 64-bit register-exchange survivors live in one state
// memory, split into two banks that swap roles every pair. A new pair is not accepted until
// the previous one has been fully processed. The 32 butterflies need two reads each from the
// single read port of that memory, so there are 64 reads. They are followed by the write-back
// tail, the decision step and the accept step. The search for the best state rides along with
// the write-back. Each output byte holds the unit until it is loaded into the output register,
// which waits while the sink stalls. A byte comes after pair 63 and after every eighth pair
// from there. At page end the best survivor's 8 bytes follow, and the last one is flagged.
// The next pair is taken only after the last byte is loaded into the output register and the
// unit has returned to idle. No memory clearing pass is needed after reset or at page restart.
module viterbi_k7_soft_decoder_unit import vitk7_pkg::*; #(
    parameter int PAGE_PAIRS = 120
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vitk7_in_if.sink    i_in,
    vitk7_out_if.source o_out
);

    t_state r_state, n_state;

    logic [PAIR_W-1:0]   r_cnt;
    logic                r_rv, r_rhi, r_hv;
    logic [HALF_W-1:0]   r_rs, r_hs;
    t_entry              r_a, r_h;
    logic [METRIC_W-1:0] r_min;
    logic [SURV_W-1:0]   r_best;
    logic                r_bank, r_fresh, r_clean;
    logic [PAIR_W-1:0]   r_pair;
    logic                r_per, r_fl;
    logic [2:0]          r_bi;
    logic [SOFT_W-1:0]   r_d1, r_d2;
    logic                r_ov, r_ol;
    logic [BYTE_W-1:0]   r_ob;

    logic                in_acc;
    logic                rd_en, wr_en, wr_first, acs_done, emit_load, can_load;
    logic [6:0]          rd_addr, wr_addr;
    t_entry              wr_data, ram_q, rd_ent, n0, n1;
    logic [NSTATE_W-1:0] rd_idx;
    logic [BM_W-1:0]     bm0, bm1, ds, dc;
    logic [1:0]          grp;
    logic [METRIC_W-1:0] a0, a1, b0, b1;
    logic [2:0]          byte_sel;
    logic                is_per, is_flush;

    vitk7_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (RAM_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    assign in_acc   = i_in.valid && i_in.ready;
    assign can_load = !r_ov || o_out.ready;
    assign is_per   = (r_pair >= FIRST_EMIT) && (r_pair[2:0] == 3'b111);
    assign is_flush = (r_pair >= PAIR_W'(PAGE_PAIRS - 1));

    // fresh page reads reset metrics, survivors read zero until the first pair after reset
    always_comb begin
        rd_idx        = {r_rhi, r_rs};
        rd_ent.metric = r_fresh ? ((rd_idx == '0) ? '0 : INIT_METRIC) : ram_q.metric;
        rd_ent.surv   = r_clean ? '0 : ram_q.surv;
    end

    // butterfly add-compare-select, lower predecessor wins ties
    always_comb begin
        bm0 = BM_W'(r_d1 ^ DIST_ZERO) + BM_W'(r_d2 ^ DIST_ZERO);
        bm1 = BM_W'(r_d1 ^ DIST_ZERO) + BM_W'(r_d2 ^ DIST_ONE);
        grp = BM_GROUP[r_rs];
        case (grp)
            2'd0:    ds = bm0;
            2'd1:    ds = bm1;
            2'd2:    ds = BM_MAX - bm1;
            2'd3:    ds = BM_MAX - bm0;
            default: ds = bm0;
        endcase
        dc = BM_MAX - ds;
        a0 = r_a.metric + METRIC_W'(ds);
        a1 = r_a.metric + METRIC_W'(dc);
        b0 = rd_ent.metric + METRIC_W'(dc);
        b1 = rd_ent.metric + METRIC_W'(ds);
        if (a0 <= b0) begin
            n0.metric = a0;
            n0.surv   = {r_a.surv[SURV_W-2:0], 1'b0};
        end else begin
            n0.metric = b0;
            n0.surv   = {rd_ent.surv[SURV_W-2:0], 1'b0};
        end
        if (a1 <= b1) begin
            n1.metric = a1;
            n1.surv   = {r_a.surv[SURV_W-2:0], 1'b1};
        end else begin
            n1.metric = b1;
            n1.surv   = {rd_ent.surv[SURV_W-2:0], 1'b1};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_ACS;
            end
            S_ACS: begin
                if (acs_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_per && !r_fl) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_first  = 1'b0;
        acs_done  = 1'b0;
        emit_load = 1'b0;
        rd_addr   = {r_bank, r_cnt[0], r_cnt[5:1]};
        wr_addr   = {!r_bank, r_hs, 1'b1};
        wr_data   = r_h;
        case (r_state)
            S_ACS: begin
                rd_en = !r_cnt[6];
                if (r_rv && r_rhi) begin
                    wr_en    = 1'b1;
                    wr_addr  = {!r_bank, r_rs, 1'b0};
                    wr_data  = n0;
                    wr_first = (r_rs == '0);
                end else if (r_hv) begin
                    wr_en    = 1'b1;
                    acs_done = (r_hs == '1);
                end
            end
            S_EMIT: begin
                emit_load = can_load && (r_per || r_fl);
            end
            default: ;
        endcase
    end

    assign byte_sel = ~r_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rv    <= 1'b0;
            r_hv    <= 1'b0;
            r_bank  <= 1'b0;
            r_fresh <= 1'b1;
            r_clean <= 1'b1;
            r_pair  <= '0;
            r_per   <= 1'b0;
            r_fl    <= 1'b0;
            r_bi    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_cnt <= '0;
            end else if (rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_rv <= rd_en;
            r_hv <= r_rv && r_rhi;
            if (acs_done) begin
                r_bank  <= !r_bank;
                r_fresh <= is_flush;
                r_clean <= 1'b0;
                r_pair  <= is_flush ? '0 : r_pair + 1'b1;
                r_per   <= is_per;
                r_fl    <= is_flush;
                r_bi    <= '0;
            end else if (emit_load) begin
                if (r_per) begin
                    r_per <= 1'b0;
                end else begin
                    r_bi <= r_bi + 1'b1;
                    if (r_bi == 3'd7) r_fl <= 1'b0;
                end
            end
            if (emit_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_d1 <= i_in.soft_first;
            r_d2 <= i_in.soft_second;
        end
        r_rhi <= r_cnt[0];
        r_rs  <= r_cnt[5:1];
        if (r_rv && !r_rhi) begin
            r_a <= rd_ent;
        end
        if (r_rv && r_rhi) begin
            r_h  <= n1;
            r_hs <= r_rs;
        end
        // writes come out in ascending state order, so strict less keeps the lowest index
        if (wr_en && (wr_first || (wr_data.metric < r_min))) begin
            r_min  <= wr_data.metric;
            r_best <= wr_data.surv;
        end
        if (emit_load) begin
            if (r_per) begin
                r_ob <= r_best[SURV_W-1 -: BYTE_W];
                r_ol <= 1'b0;
            end else begin
                r_ob <= r_best[{byte_sel, 3'b000} +: BYTE_W];
                r_ol <= (r_bi == 3'd7);
            end
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.out_byte  = r_ob;
    assign o_out.page_last = r_ol;

    a_wr_other_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr[6] != r_bank))
        else $error("state write hits the bank being read");

    a_no_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rv && r_rhi) |-> !r_hv)
        else $error("two write-backs in one cycle");

    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair < PAIR_W'(PAGE_PAIRS))
        else $error("pair counter beyond page length");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_ACS) && (r_cnt == '0))
        else $error("accepted beat did not start a butterfly pass");

    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && !r_per && (r_bi == 3'd7)) |=> !r_fl)
        else $error("flush did not end after its eighth byte");

endmodule
